// File: rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int PAGE_W  = 16;   // page field on the ports
  localparam int SLOT_W  = 2;    // frame_slot field on the ports
  localparam int FAULT_W = 32;   // fault counter width
  localparam int CFG_W   = 3;    // active_frames register width
  localparam int ADDR_W  = 3;    // config byte address width
  localparam int DATA_W  = 32;   // config data width

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 3'd3;

  // Register index, taken from config address bit 2 (word address).
  typedef enum logic [0:0] {
    REG_ACTIVE_FRAMES = 1'b0
  } lpr_reg_t;

  // One lookup outcome as it leaves the frame table.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] frame_slot;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
  } lpr_result_t;

endpackage

// File: rtl/lpr_frame_table.sv
// ----------------------------------------------------------------------------
// lpr_frame_table
// Frame storage with parallel tag match, LRU victim pick and recency update.
// ----------------------------------------------------------------------------
module lpr_frame_table import lpr_pkg::*; #(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           upd_en,
  input  logic [PAGE_BITS-1:0]           page,
  input  logic [$clog2(FRAMES + 1)-1:0]  act,
  output lpr_result_t                    res
);

  localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  logic [PAGE_BITS-1:0] page_r   [FRAMES];
  logic [SW-1:0]        rank_r   [FRAMES];
  logic [FRAMES-1:0]    valid_r;
  logic [CW-1:0]        filled_r;

  logic [PAGE_BITS-1:0] page_nxt [FRAMES];
  logic [SW-1:0]        rank_nxt [FRAMES];
  logic [FRAMES-1:0]    valid_nxt;
  logic [CW-1:0]        filled_nxt;

  logic [FRAMES-1:0]    in_act;
  logic [FRAMES-1:0]    match;
  logic [FRAMES-1:0]    hit_oh;
  logic [FRAMES-1:0]    fill_oh;
  logic [FRAMES-1:0]    victim_oh;
  logic [FRAMES-1:0]    sel_oh;
  logic                 hit;
  logic                 fill;
  logic [SW-1:0]        slot;
  logic [SW-1:0]        old_rank;
  logic [PAGE_BITS-1:0] victim_page;

  // Tag match and victim pick over the active frames.
  always_comb begin
    for (int j = 0; j < FRAMES; j++) begin
      in_act[j]  = (CW'(j) < act);
      match[j]   = valid_r[j] & in_act[j] & (page_r[j] == page);
      fill_oh[j] = (CW'(j) == filled_r);
    end
    // lowest matching frame wins
    hit_oh = match & (~match + FRAMES'(1));
    hit    = |match;
    fill   = !hit && (filled_r < act);

    // oldest active frame; equal ranks go to the lower index
    for (int j = 0; j < FRAMES; j++) begin
      victim_oh[j] = in_act[j];
      for (int k = 0; k < FRAMES; k++) begin
        if (in_act[k] && ((rank_r[k] > rank_r[j]) || ((rank_r[k] == rank_r[j]) && (k < j)))) begin
          victim_oh[j] = 1'b0;
        end
      end
    end

    priority if (hit) begin
      sel_oh = hit_oh;
    end else if (fill) begin
      sel_oh = fill_oh;
    end else begin
      sel_oh = victim_oh;
    end

    slot        = '0;
    old_rank    = '0;
    victim_page = '0;
    for (int j = 0; j < FRAMES; j++) begin
      if (sel_oh[j]) begin
        slot     = slot | SW'(j);
        old_rank = old_rank | rank_r[j];
      end
      if (victim_oh[j]) begin
        victim_page = victim_page | page_r[j];
      end
    end
  end

  // Recency refresh and frame fill.
  always_comb begin
    for (int j = 0; j < FRAMES; j++) begin
      page_nxt[j]  = page_r[j];
      rank_nxt[j]  = rank_r[j];
      valid_nxt[j] = valid_r[j] | (fill & sel_oh[j]);
      if (sel_oh[j]) begin
        rank_nxt[j] = '0;
        if (!hit) begin
          page_nxt[j] = page;
        end
      end else if (valid_r[j] && (fill || (rank_r[j] < old_rank))) begin
        rank_nxt[j] = rank_r[j] + SW'(1);
      end
    end
    filled_nxt = filled_r + CW'(fill);
  end

  always_comb begin
    res.hit           = hit;
    res.frame_slot    = SLOT_W'(slot);
    res.evicted_valid = !hit && !fill;
    res.evicted_page  = (!hit && !fill) ? PAGE_W'(victim_page) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      filled_r <= '0;
      for (int j = 0; j < FRAMES; j++) begin
        rank_r[j] <= '0;
      end
    end else if (upd_en) begin
      valid_r  <= valid_nxt;
      filled_r <= filled_nxt;
      for (int j = 0; j < FRAMES; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      for (int j = 0; j < FRAMES; j++) begin
        page_r[j] <= page_nxt[j];
      end
    end
  end

endmodule

// File: rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement unit: one page reference in, one hit/fault word out.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Word
//  -------  ---------  -------------------  ---------------------------------
//  in_      input      in_valid/in_ready    page
//  out_     output     out_valid/out_ready  hit, frame_slot, evicted_valid,
//                                           evicted_page, fault_count
//  cfg_     APB slave  psel/penable/pready  active_frames at byte address 0
//
//  One word per cycle sustained while out_ready holds high; a taken word passes
//  through the input register, then the output register that drives out_valid.
//  The input register feeds the frame table, whose match, LRU pick and rank
//  update are all combinational and land in the frame state and the output
//  register at the same edge, so the next word sees the updated frames.
//  Reset (rst_n low, synchronous) empties all frames and clears the fault
//  count; active_frames returns to 3. No clearing pass is needed.
//  A stalled output holds its word; the input register still accepts one
//  word behind it, then in_ready drops until out_ready returns.
//
module lru_page_replacement import lpr_pkg::*; #(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output logic [DATA_W-1:0]  cfg_prdata,
  output logic               cfg_pready,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PAGE_W-1:0]  in_page,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [SLOT_W-1:0]  out_frame_slot,
  output logic               out_evicted_valid,
  output logic [PAGE_W-1:0]  out_evicted_page,
  output logic [FAULT_W-1:0] out_fault_count
);

  localparam int CW = $clog2(FRAMES + 1);

  logic [CFG_W-1:0]     active_r;
  logic                 s1_valid_r;
  logic [PAGE_BITS-1:0] s1_page_r;
  logic                 out_valid_r;
  lpr_result_t          out_res_r;
  logic [FAULT_W-1:0]   fault_r;
  logic [FAULT_W-1:0]   fault_nxt;

  logic                 cfg_wr;
  logic                 advance;
  logic                 proc;
  logic [CW-1:0]        act;
  lpr_result_t          res;

  // --- configuration port --------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE_FRAMES) ? DATA_W'(active_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_ACTIVE_FRAMES)) begin
      active_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // Clamp the frame count: zero acts as one, anything above FRAMES as FRAMES.
  always_comb begin
    priority if (active_r == '0) begin
      act = CW'(1);
    end else if (32'(active_r) > 32'(FRAMES)) begin
      act = CW'(FRAMES);
    end else begin
      act = CW'(active_r);
    end
  end

  // --- flow control ----------------------------------------------------------
  // Advance the input register into the output register whenever the output
  // is empty or being taken; accept a new word whenever the input register
  // is empty or empties in the same cycle.
  assign advance  = !out_valid_r || out_ready;
  assign proc     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_page_r <= PAGE_BITS'(in_page);
    end
  end

  // --- frame table -----------------------------------------------------------
  lpr_frame_table #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (proc),
    .page   (s1_page_r),
    .act    (act),
    .res    (res)
  );

  // --- fault counter: count every miss, hold at all ones ---------------------
  assign fault_nxt = (!res.hit && (fault_r != '1)) ? fault_r + FAULT_W'(1) : fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
    end else if (proc) begin
      fault_r <= fault_nxt;
    end
  end

  // --- output register -------------------------------------------------------
  // fault_r changes only when a new word loads, so it doubles as the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_res_r.hit;
  assign out_frame_slot    = out_res_r.frame_slot;
  assign out_evicted_valid = out_res_r.evicted_valid;
  assign out_evicted_page  = out_res_r.evicted_page;
  assign out_fault_count   = fault_r;

endmodule

// File: rtl/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks for the LRU page replacement block, bound to the top.
// ----------------------------------------------------------------------------
module lpr_checker import lpr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_hit,
  input logic [SLOT_W-1:0]  out_frame_slot,
  input logic               out_evicted_valid,
  input logic [PAGE_W-1:0]  out_evicted_page,
  input logic [FAULT_W-1:0] out_fault_count
);

  logic [FAULT_W-1:0] last_fault_r;

  // Track the fault count of the last word taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_fault_r <= '0;
    end else if (out_valid && out_ready) begin
      last_fault_r <= out_fault_count;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit)
      && $stable(out_frame_slot) && $stable(out_evicted_page)
      && $stable(out_fault_count)))
    else $error("output word changed while stalled");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted_valid))
    else $error("eviction reported on a hit");

  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_hit) |-> (out_fault_count == last_fault_r))
    else $error("fault count moved on a hit");

  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_hit) |->
      ((out_fault_count == last_fault_r + FAULT_W'(1))
       || ((last_fault_r == '1) && (out_fault_count == '1))))
    else $error("fault count did not step on a miss");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);

// File: dv/lpr_outcome_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_outcome_pkg
// Frame-table predictor and result scoreboard for the LRU page replacement
// block: tracks frames, ages and fault count, queues expected words.
// ----------------------------------------------------------------------------
package lpr_outcome_pkg;
  import lpr_pkg::*;

  localparam int TABLE_FRAMES = 4;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    lpr_result_t        res;
    logic [FAULT_W-1:0] faults;
  } outcome_t;

  class page_outcome_board;
    logic [PAGE_W-1:0]       held_page [TABLE_FRAMES];
    bit                      occupied  [TABLE_FRAMES];
    int unsigned             age       [TABLE_FRAMES];
    int unsigned             filled;
    logic [FAULT_W-1:0]      faults;
    logic [CFG_W-1:0]        active_reg;
    outcome_t                outcomes_due[$];
    int unsigned             mismatches;
    int unsigned             checked;
    int unsigned             hits;
    int unsigned             misses;
    int unsigned             evictions;
    bit [(1<<CFG_W)-1:0]     settings_seen;

    function new();
      active_reg    = ACTIVE_RESET;
      filled        = 0;
      faults        = '0;
      mismatches    = 0;
      checked       = 0;
      hits          = 0;
      misses        = 0;
      evictions     = 0;
      settings_seen = '0;
      foreach (held_page[j]) begin
        held_page[j] = '0;
        occupied[j]  = 1'b0;
        age[j]       = 0;
      end
    endfunction

    function void set_active(logic [CFG_W-1:0] value);
      active_reg = value;
      settings_seen[value] = 1'b1;
    endfunction

    function int unsigned pending();
      return outcomes_due.size();
    endfunction

    // Zero acts as one frame, anything past the table as the whole table.
    function int unsigned span();
      if (active_reg == 0) return 1;
      if (active_reg > TABLE_FRAMES) return TABLE_FRAMES;
      return active_reg;
    endfunction

    // Make frame f the youngest; frames younger than its old age get older.
    function void promote(int unsigned f, int unsigned old_age);
      for (int j = 0; j < TABLE_FRAMES; j++) begin
        if (j != f && occupied[j] && age[j] < old_age) age[j]++;
      end
      age[f] = 0;
    endfunction

    function void note_reference(logic [PAGE_W-1:0] page);
      int unsigned act;
      int unsigned slot;
      int unsigned victim;
      bit          found;
      outcome_t    want;
      act   = span();
      slot  = 0;
      found = 1'b0;
      want  = '0;
      for (int j = 0; j < act; j++) begin
        if (!found && occupied[j] && held_page[j] == page) begin
          found = 1'b1;
          slot  = j;
        end
      end
      if (found) begin
        promote(slot, age[slot]);
        hits++;
      end else begin
        if (filled < act) begin
          slot            = filled;
          held_page[slot] = page;
          occupied[slot]  = 1'b1;
          promote(slot, TABLE_FRAMES);
          filled++;
        end else begin
          victim = 0;
          for (int j = 1; j < act; j++) begin
            if (age[j] > age[victim]) victim = j;
          end
          slot                   = victim;
          want.res.evicted_valid = 1'b1;
          want.res.evicted_page  = held_page[slot];
          held_page[slot]        = page;
          promote(slot, age[slot]);
          evictions++;
        end
        if (faults != '1) faults++;
        misses++;
      end
      want.res.hit        = found;
      want.res.frame_slot = SLOT_W'(slot);
      want.faults         = faults;
      outcomes_due.push_back(want);
    endfunction

    function void check_outcome(lpr_result_t got, logic [FAULT_W-1:0] got_faults);
      outcome_t want;
      if (outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected word: hit=%0b slot=%0d evict=%0b/%h faults=%0d",
                   got.hit, got.frame_slot, got.evicted_valid, got.evicted_page,
                   got_faults);
        return;
      end
      want = outcomes_due.pop_front();
      checked++;
      if (want.res.hit !== got.hit || want.res.frame_slot !== got.frame_slot ||
          want.res.evicted_valid !== got.evicted_valid ||
          want.res.evicted_page !== got.evicted_page || want.faults !== got_faults) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("word %0d: expected hit=%0b slot=%0d evict=%0b/%h faults=%0d, got hit=%0b slot=%0d evict=%0b/%h faults=%0d",
                   checked, want.res.hit, want.res.frame_slot, want.res.evicted_valid,
                   want.res.evicted_page, want.faults, got.hit, got.frame_slot,
                   got.evicted_valid, got.evicted_page, got_faults);
      end
    endfunction
  endclass

endpackage

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_page_replacement: directed frame-table cases,
// then randomized reference streams over many active-frame settings, with
// bursty input, output back-pressure and per-word checking of every field.
// ----------------------------------------------------------------------------
module tb;
  import lpr_pkg::*;
  import lpr_outcome_pkg::*;

  localparam int RANDOM_PHASES   = 12;
  localparam int PHASE_REFS      = 78;
  localparam int SETTLE_CYCLES   = 4;    // idle margin after the last word is back
  localparam int TIMEOUT_NS      = 5_000_000;
  localparam logic [ADDR_W-1:0] ACTIVE_ADDR = ADDR_W'(4 * int'(REG_ACTIVE_FRAMES));

  typedef enum {RX_STREAM, RX_CHOPPY, RX_STARVED} rx_style_e;

  logic               clk;
  logic               rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [ADDR_W-1:0]  cfg_paddr;
  logic [DATA_W-1:0]  cfg_pwdata;
  logic [DATA_W-1:0]  cfg_prdata;
  logic               cfg_pready;
  logic               in_valid;
  logic               in_ready;
  logic [PAGE_W-1:0]  in_page;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_frame_slot;
  logic               out_evicted_valid;
  logic [PAGE_W-1:0]  out_evicted_page;
  logic [FAULT_W-1:0] out_fault_count;

  page_outcome_board  book;

  // Stimulus shaping, set per phase by the driver.
  rx_style_e          stall_style = RX_STREAM;
  int                 gap_max;
  int                 burst_max;
  int                 hot_span;
  logic [PAGE_W-1:0]  hot_pages [8];

  // Receiver pattern state.
  int                 rx_left = 0;
  bit                 rx_open = 1'b1;

  lru_page_replacement #(
    .FRAMES    (TABLE_FRAMES),
    .PAGE_BITS (PAGE_W)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_frame_slot    (out_frame_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count)
  );

  always #5 clk = ~clk;

  // Receiver: alternate ready and stalled runs whose lengths depend on the
  // current style; streaming style never stalls.
  always @(posedge clk) begin
    if (!rst_n || stall_style == RX_STREAM) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_open = !rx_open;
        if (stall_style == RX_CHOPPY) begin
          rx_left = rx_open ? $urandom_range(1, 8) : $urandom_range(1, 4);
        end else begin
          rx_left = rx_open ? $urandom_range(1, 2) : $urandom_range(3, 12);
        end
      end
      rx_left--;
      out_ready <= rx_open;
    end
  end

  // Check every word that leaves the block against the oldest expectation.
  // Sampling right at the edge sees the values held just before it, as the edge takes them.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      book.check_outcome({out_hit, out_frame_slot, out_evicted_valid, out_evicted_page},
                         out_fault_count);
    end
  end

  // Offer one page and hold it until accepted; predict the outcome at the
  // accepting edge so expectations queue up in acceptance order.
  task automatic send_page(input logic [PAGE_W-1:0] page);
    in_valid <= 1'b1;
    in_page  <= page;
    do @(posedge clk); while (!in_ready);
    book.note_reference(page);
  endtask

  // Drop valid for a gap; a zero gap keeps the stream going back to back.
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected word has come back, then let
  // the pipeline settle so the block is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase APB write of active_frames; the register takes the value at
  // the access edge where pready is seen high.
  task automatic write_active(input logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ACTIVE_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    book.set_active(value[CFG_W-1:0]);
  endtask

  // Mostly in-range frame counts, sometimes the out-of-range codes, and now
  // and then junk in the unused upper bits.
  function automatic logic [DATA_W-1:0] pick_active_word();
    logic [DATA_W-1:0] word;
    word = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      word[CFG_W-1:0] = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
    end else begin
      word[CFG_W-1:0] = CFG_W'($urandom_range(1, TABLE_FRAMES));
    end
    if ($urandom_range(0, 3) != 0) word[DATA_W-1:CFG_W] = '0;
    return word;
  endfunction

  // Favor a small hot set of pages so hits, refreshes and LRU evictions
  // dominate; mix in fresh pages, the extremes and walking ones.
  function automatic logic [PAGE_W-1:0] pick_page();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return hot_pages[$urandom_range(0, hot_span - 1)];
    if (roll < 90) return PAGE_W'($urandom);
    if (roll < 95) return roll[0] ? '1 : '0;
    return PAGE_W'(1) << $urandom_range(0, PAGE_W - 1);
  endfunction

  initial begin
    int left;
    int burst;
    book        = new();
    clk         = 1'b0;
    rst_n       <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    in_valid    <= 1'b0;
    in_page     <= '0;
    gap_max     = 0;
    burst_max   = 1;
    hot_span    = 2;
    foreach (hot_pages[j]) hot_pages[j] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Cold fill with the reset setting of three frames, then hits that
    // refresh recency and two faults that evict the oldest frame.
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h8000);
    send_page(16'hFFFF);
    send_page(16'h7FFF);
    send_page(16'h0000);
    drain_results();

    // Widen to the whole table: the last empty frame gets filled.
    write_active(32'd4);
    send_page(16'h1234);
    send_page(16'hFFFF);
    drain_results();

    // Shrink to one frame: page 0000 now sits only in an inactive frame,
    // so referencing it faults and lands a duplicate in frame 0.
    write_active(32'd1);
    send_page(16'h0000);
    drain_results();

    // Code above the table acts as the full table; the duplicate resolves
    // to the lowest-numbered frame.
    write_active(32'h0000_0007);
    send_page(16'h0000);
    drain_results();

    // Zero in the register field (upper bits all set) acts as one frame.
    write_active(32'hFFFF_FFF8);
    send_page(16'h5555);
    send_page(16'hAAAA);
    drain_results();

    write_active(32'd5);
    send_page(16'h1234);
    send_page(16'hFFFF);
    send_page(16'h00FF);
    send_page(16'hFF00);
    drain_results();

    // Random phases: each with its own frame count, hot set, sender burst
    // shape and receiver stall style. The first phase runs flat out.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      write_active(pick_active_word());
      hot_span = $urandom_range(2, 8);
      foreach (hot_pages[j]) hot_pages[j] = PAGE_W'($urandom);
      if (ph == 0) begin
        stall_style = RX_STREAM;
        gap_max     = 0;
        burst_max   = PHASE_REFS;
      end else begin
        stall_style = rx_style_e'($urandom_range(0, 2));
        case ($urandom_range(0, 2))
          0: begin
            gap_max = 0;
          end
          1: begin
            gap_max = 3;
          end
          default: begin
            gap_max = 20;
          end
        endcase
        burst_max = $urandom_range(1, 16);
      end
      left = PHASE_REFS;
      while (left > 0) begin
        burst = $urandom_range(1, burst_max);
        for (int k = 0; k < burst && left > 0; k++) begin
          send_page(pick_page());
          left--;
        end
        // Now and then hold the sender until everything has come back.
        if ($urandom_range(0, 19) == 0) drain_results();
        else pause_sender($urandom_range(0, gap_max));
      end
    end

    // Wait out the last words, plus an idle margin for anything stray.
    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d words: %0d hits, %0d faults, %0d evictions",
             book.checked, book.hits, book.misses, book.evictions);
    $display("active-frame codes written (bit per code): %b, mismatches: %0d, outstanding: %0d",
             book.settings_seen, book.mismatches, book.pending());
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d words outstanding", book.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
